// ----- rtl/core/fault_latch_health_monitor_assert.svh -----
// Assertion macros for the fault latch health monitor checker.
// Needs nothing else; the including file supplies clock and reset names.
`ifndef FAULT_LATCH_HEALTH_MONITOR_ASSERT_SVH
`define FAULT_LATCH_HEALTH_MONITOR_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define FLHM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("flhm assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define FLHM_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flhm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FLHM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flhm assertion failed");

`endif

// ----- rtl/core/flhm_pkg.sv -----
// Shared constants for the fault latch health monitor.
// Used by the channel interfaces, the top level and its checker.
package flhm_pkg;

   localparam int TIME_WIDTH_DEF = 32;
   localparam int RPM_WIDTH_DEF  = 16;

   // Configuration registers are all 16 bits wide.
   localparam int CFG_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HB_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MM_LIMIT   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MM_HOLD    = 2'd2;

   localparam logic [CFG_WIDTH-1:0] HB_TIMEOUT_RESET = 16'd500;
   localparam logic [CFG_WIDTH-1:0] MM_LIMIT_RESET   = 16'd500;
   localparam logic [CFG_WIDTH-1:0] MM_HOLD_RESET    = 16'd1000;

   // Health levels reported on the result channel.
   localparam int HEALTH_WIDTH = 2;
   localparam logic [HEALTH_WIDTH-1:0] HEALTH_HEALTHY  = 2'd0;
   localparam logic [HEALTH_WIDTH-1:0] HEALTH_DEGRADED = 2'd1;
   localparam logic [HEALTH_WIDTH-1:0] HEALTH_SAFE     = 2'd2;

   // Fault flag positions.
   localparam int NUM_FAULTS   = 4;
   localparam int FAULT_COMM   = 0;
   localparam int FAULT_HB     = 1;
   localparam int FAULT_SENSOR = 2;
   localparam int FAULT_ACT    = 3;

endpackage

// ----- rtl/core/flhm_if.sv -----
// Valid/ready channel interfaces of the fault latch health monitor.
// Depends on flhm_pkg for the default widths, the health code width and the register index and data widths.
interface flhm_req_if #(
   parameter int TIME_WIDTH = flhm_pkg::TIME_WIDTH_DEF,
   parameter int RPM_WIDTH  = flhm_pkg::RPM_WIDTH_DEF
);
   logic                  valid;
   logic                  ready;
   logic [TIME_WIDTH-1:0] now_ms;
   logic                  link_up;
   logic                  heard_any;
   logic [TIME_WIDTH-1:0] last_heard_ms;
   logic                  sensor_ok;
   logic [RPM_WIDTH-1:0]  target_rpm;
   logic [RPM_WIDTH-1:0]  measured_rpm;

   modport source (output valid, now_ms, link_up, heard_any, last_heard_ms, sensor_ok,
                   target_rpm, measured_rpm, input ready);
   modport sink   (input valid, now_ms, link_up, heard_any, last_heard_ms, sensor_ok,
                   target_rpm, measured_rpm, output ready);
endinterface

interface flhm_rsp_if #(
   parameter int TIME_WIDTH = flhm_pkg::TIME_WIDTH_DEF
);
   logic                              valid;
   logic                              ready;
   logic [flhm_pkg::HEALTH_WIDTH-1:0] health_state;
   logic                              comm_fault;
   logic                              heartbeat_fault;
   logic                              sensor_fault;
   logic                              actuator_fault;
   logic [TIME_WIDTH-1:0]             comm_fault_time;
   logic [TIME_WIDTH-1:0]             heartbeat_fault_time;
   logic [TIME_WIDTH-1:0]             sensor_fault_time;
   logic [TIME_WIDTH-1:0]             actuator_fault_time;

   modport source (output valid, health_state, comm_fault, heartbeat_fault, sensor_fault,
                   actuator_fault, comm_fault_time, heartbeat_fault_time,
                   sensor_fault_time, actuator_fault_time, input ready);
   modport sink   (input valid, health_state, comm_fault, heartbeat_fault, sensor_fault,
                   actuator_fault, comm_fault_time, heartbeat_fault_time,
                   sensor_fault_time, actuator_fault_time, output ready);
endinterface

interface flhm_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [flhm_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [flhm_pkg::CFG_WIDTH-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/fault_latch_health_monitor.sv -----
// Fault latch health monitor: fault flag tracking and health reporting.
// Depends on flhm_pkg and the channel interfaces in flhm_if.sv.
//
// Usage. Each item on req_ch is one evaluation tick: the time in ms, the
// link and heartbeat status, the sensor-valid bit and commanded and measured
// rpm. Every item produces exactly one item on rsp_ch holding the health
// level, the four fault flags and the time each flag was last newly raised.
// csr_ch writes the heartbeat timeout, the rpm mismatch limit and the
// mismatch hold time; it is always ready, and writes to an unused index are
// dropped. Registers should be written only while no item is in flight.
//
// Timing. An accepted item is registered in the input stage, evaluated against
// the fault state when the output stage can move, and its result is
// registered in the output stage, from which it shows on rsp_ch. One item
// is accepted every cycle while results are taken; the fault state loop
// needs one subtract and compare per check.
//
// Reset clears the fault flags, raise times and mismatch tracking, empties
// both stages and loads the register defaults. When the receiver stalls the
// result is held in the output register; an empty input stage can still take
// one more item, after which req_ch.ready stays low until the result is taken.
module fault_latch_health_monitor #(
   parameter int TIME_WIDTH = flhm_pkg::TIME_WIDTH_DEF,
   parameter int RPM_WIDTH  = flhm_pkg::RPM_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   flhm_req_if.sink  req_ch,
   flhm_rsp_if.source rsp_ch,
   flhm_csr_if.sink  csr_ch
);

   // The rpm difference is compared against a 16-bit limit; use whichever
   // is wider so no bits are lost.
   localparam int CMP_WIDTH = (RPM_WIDTH > flhm_pkg::CFG_WIDTH) ? RPM_WIDTH
                                                                 : flhm_pkg::CFG_WIDTH;

   // Configuration registers.
   logic [flhm_pkg::CFG_WIDTH-1:0] hb_timeout_ff;
   logic [flhm_pkg::CFG_WIDTH-1:0] mm_limit_ff;
   logic [flhm_pkg::CFG_WIDTH-1:0] mm_hold_ff;

   // Input stage.
   logic                  s1_valid_ff;
   logic [TIME_WIDTH-1:0] now_ff;
   logic                  link_ff;
   logic                  heard_ff;
   logic [TIME_WIDTH-1:0] last_ff;
   logic                  sens_ok_ff;
   logic [RPM_WIDTH-1:0]  cmd_ff;
   logic [RPM_WIDTH-1:0]  meas_ff;

   // Fault state.
   logic [flhm_pkg::NUM_FAULTS-1:0] flags_ff;
   logic [flhm_pkg::NUM_FAULTS-1:0] flags_in;
   logic [TIME_WIDTH-1:0]           ftime_ff [flhm_pkg::NUM_FAULTS];
   logic [TIME_WIDTH-1:0]           ftime_in [flhm_pkg::NUM_FAULTS];
   logic [TIME_WIDTH-1:0]           mm_start_ff;
   logic [TIME_WIDTH-1:0]           mm_start_in;
   logic                            mm_run_ff;
   logic                            mm_run_in;

   // Output stage.
   logic                              out_valid_ff;
   logic [flhm_pkg::HEALTH_WIDTH-1:0] health_ff;
   logic [flhm_pkg::HEALTH_WIDTH-1:0] health_in;

   // Evaluation signals.
   logic                            s2_adv;
   logic                            s1_adv;
   logic                            eval;
   logic [flhm_pkg::NUM_FAULTS-1:0] raise;
   logic [TIME_WIDTH-1:0]           hb_gap;
   logic [RPM_WIDTH-1:0]            rpm_diff;
   logic                            mismatching;
   logic [TIME_WIDTH-1:0]           start_eff;
   logic [TIME_WIDTH-1:0]           mm_gap;
   logic                            sustained;

   // The output register moves when it is empty or being taken; the input
   // stage moves when it is empty or its item is moving on.
   assign s2_adv       = !out_valid_ff || rsp_ch.ready;
   assign s1_adv       = !s1_valid_ff || s2_adv;
   assign eval         = s1_valid_ff && s2_adv;
   assign req_ch.ready = s1_adv;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hb_timeout_ff <= flhm_pkg::HB_TIMEOUT_RESET;
         mm_limit_ff   <= flhm_pkg::MM_LIMIT_RESET;
         mm_hold_ff    <= flhm_pkg::MM_HOLD_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            flhm_pkg::CSR_HB_TIMEOUT: hb_timeout_ff <= csr_ch.data;
            flhm_pkg::CSR_MM_LIMIT:   mm_limit_ff   <= csr_ch.data;
            flhm_pkg::CSR_MM_HOLD:    mm_hold_ff    <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && req_ch.valid) begin
         now_ff     <= req_ch.now_ms;
         link_ff    <= req_ch.link_up;
         heard_ff   <= req_ch.heard_any;
         last_ff    <= req_ch.last_heard_ms;
         sens_ok_ff <= req_ch.sensor_ok;
         cmd_ff     <= req_ch.target_rpm;
         meas_ff    <= req_ch.measured_rpm;
      end
   end

   // Heartbeat check: skipped while the link is down or before any
   // heartbeat; a last-heard time later than now never counts as timed out.
   assign hb_gap = now_ff - last_ff;

   // Mismatch tracking. A mismatch that starts on this tick starts its timer
   // now, so a zero hold time raises the actuator fault at once.
   assign rpm_diff    = (cmd_ff >= meas_ff) ? (cmd_ff - meas_ff) : (meas_ff - cmd_ff);
   assign mismatching = (cmd_ff != '0) &&
                        (CMP_WIDTH'(rpm_diff) > CMP_WIDTH'(mm_limit_ff));
   assign start_eff   = (mismatching && !mm_run_ff) ? now_ff : mm_start_ff;
   assign mm_gap      = now_ff - start_eff;
   assign sustained   = mismatching && (now_ff >= start_eff) &&
                        (mm_gap >= TIME_WIDTH'(mm_hold_ff));
   assign mm_run_in   = mismatching;
   assign mm_start_in = mismatching ? start_eff : '0;

   always_comb begin
      raise = '0;
      raise[flhm_pkg::FAULT_COMM]   = !link_ff;
      raise[flhm_pkg::FAULT_HB]     = link_ff && heard_ff && (now_ff >= last_ff) &&
                                      (hb_gap > TIME_WIDTH'(hb_timeout_ff));
      raise[flhm_pkg::FAULT_SENSOR] = !sens_ok_ff;
      raise[flhm_pkg::FAULT_ACT]    = sustained;

      // Communication and heartbeat faults latch; the other two follow
      // their condition on every tick.
      flags_in = raise;
      flags_in[flhm_pkg::FAULT_COMM] = flags_ff[flhm_pkg::FAULT_COMM] ||
                                       raise[flhm_pkg::FAULT_COMM];
      flags_in[flhm_pkg::FAULT_HB]   = flags_ff[flhm_pkg::FAULT_HB] ||
                                       raise[flhm_pkg::FAULT_HB];

      // A raise time is recorded only when the flag goes from clear to set.
      for (int i = 0; i < flhm_pkg::NUM_FAULTS; i++) begin
         ftime_in[i] = (raise[i] && !flags_ff[i]) ? now_ff : ftime_ff[i];
      end

      if (flags_in[flhm_pkg::FAULT_COMM] || flags_in[flhm_pkg::FAULT_HB]) begin
         health_in = flhm_pkg::HEALTH_SAFE;
      end else if (flags_in[flhm_pkg::FAULT_SENSOR] || flags_in[flhm_pkg::FAULT_ACT]) begin
         health_in = flhm_pkg::HEALTH_DEGRADED;
      end else begin
         health_in = flhm_pkg::HEALTH_HEALTHY;
      end
   end

   // Fault state doubles as the result payload: the output stage shows the
   // state left by the item it holds.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff    <= '0;
         mm_start_ff <= '0;
         mm_run_ff   <= 1'b0;
         health_ff   <= flhm_pkg::HEALTH_HEALTHY;
         for (int i = 0; i < flhm_pkg::NUM_FAULTS; i++) begin
            ftime_ff[i] <= '0;
         end
      end else if (eval) begin
         flags_ff    <= flags_in;
         mm_start_ff <= mm_start_in;
         mm_run_ff   <= mm_run_in;
         health_ff   <= health_in;
         for (int i = 0; i < flhm_pkg::NUM_FAULTS; i++) begin
            ftime_ff[i] <= ftime_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   assign rsp_ch.valid                = out_valid_ff;
   assign rsp_ch.health_state         = health_ff;
   assign rsp_ch.comm_fault           = flags_ff[flhm_pkg::FAULT_COMM];
   assign rsp_ch.heartbeat_fault      = flags_ff[flhm_pkg::FAULT_HB];
   assign rsp_ch.sensor_fault         = flags_ff[flhm_pkg::FAULT_SENSOR];
   assign rsp_ch.actuator_fault       = flags_ff[flhm_pkg::FAULT_ACT];
   assign rsp_ch.comm_fault_time      = ftime_ff[flhm_pkg::FAULT_COMM];
   assign rsp_ch.heartbeat_fault_time = ftime_ff[flhm_pkg::FAULT_HB];
   assign rsp_ch.sensor_fault_time    = ftime_ff[flhm_pkg::FAULT_SENSOR];
   assign rsp_ch.actuator_fault_time  = ftime_ff[flhm_pkg::FAULT_ACT];

endmodule

// ----- rtl/core/flhm_checker.sv -----
// Port-level checker for the fault latch health monitor, bound to the top.
// Depends on flhm_pkg and fault_latch_health_monitor_assert.svh.
`include "fault_latch_health_monitor_assert.svh"

module flhm_checker #(
   parameter int TIME_WIDTH = flhm_pkg::TIME_WIDTH_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [flhm_pkg::HEALTH_WIDTH-1:0] rsp_health,
   input logic                              rsp_comm,
   input logic                              rsp_hb,
   input logic                              rsp_sensor,
   input logic                              rsp_act,
   input logic [TIME_WIDTH-1:0]             rsp_comm_time
);

   // A stalled result keeps its health level.
   `FLHM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_health))

   // Health level agrees with the flags it summarizes.
   `FLHM_ASSERT_SAME(a_health_flags, clock, reset, rsp_valid,
      ((rsp_comm || rsp_hb) && rsp_health == flhm_pkg::HEALTH_SAFE) ||
      (!rsp_comm && !rsp_hb && (rsp_sensor || rsp_act) &&
       rsp_health == flhm_pkg::HEALTH_DEGRADED) ||
      (!rsp_comm && !rsp_hb && !rsp_sensor && !rsp_act &&
       rsp_health == flhm_pkg::HEALTH_HEALTHY))

   // A latched communication fault stays set, with its raise time, in the
   // result that follows in the next cycle.
   `FLHM_ASSERT_NEXT(a_comm_latch, clock, reset, rsp_valid && rsp_ready && rsp_comm,
                     !rsp_valid || (rsp_comm && $stable(rsp_comm_time)))

   // Health never shows the unused code.
   `FLHM_ASSERT(a_health_code, clock, reset,
                !rsp_valid || rsp_health != 2'd3)

endmodule

bind fault_latch_health_monitor flhm_checker #(
   .TIME_WIDTH(TIME_WIDTH)
) u_flhm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_health    (rsp_ch.health_state),
   .rsp_comm      (rsp_ch.comm_fault),
   .rsp_hb        (rsp_ch.heartbeat_fault),
   .rsp_sensor    (rsp_ch.sensor_fault),
   .rsp_act       (rsp_ch.actuator_fault),
   .rsp_comm_time (rsp_ch.comm_fault_time)
);
